### sv/bank_switch_mapper_irq_top_macros.svh
// Assertion macros for the bank-switch mapper.
// Expects clk and rst_n in scope at the point of use.
`ifndef BANK_SWITCH_MAPPER_IRQ_TOP_MACROS_SVH
`define BANK_SWITCH_MAPPER_IRQ_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define BSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/bsm_pkg.sv
// Shared types, address decode constants and helper functions of the mapper.
// No dependencies.
`timescale 1ns / 1ps

package bsm_pkg;

    localparam int CHR_SLOTS  = 8;
    localparam int CHR_SLOT_W = $clog2(CHR_SLOTS);

    // Upper address nibble codes
    localparam logic [3:0] HI_MIR_PRG = 4'h9;
    localparam logic [3:0] HI_CHR_A   = 4'hA;
    localparam logic [3:0] HI_CHR_B   = 4'hB;
    localparam logic [3:0] HI_SPLIT   = 4'hC;
    localparam logic [3:0] HI_CHR_D   = 4'hD;
    localparam logic [3:0] HI_CHR_E   = 4'hE;
    localparam logic [3:0] HI_IRQ     = 4'hF;

    // Register offsets, address bits 3:2
    localparam logic [1:0] OFF_0 = 2'd0;
    localparam logic [1:0] OFF_1 = 2'd1;
    localparam logic [1:0] OFF_2 = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG32 = 2'd0;
    localparam logic [1:0] CFG_PRG8  = 2'd1;
    localparam logic [1:0] CFG_CHR   = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        logic        irq_line;
        logic [1:0]  mirroring;
        logic [7:0]  prg_bank_32k;
        logic        prg_split_on;
        logic [7:0]  prg_bank_8k_c000;
        logic        chr_write_valid;
        logic [2:0]  chr_slot;
        logic [7:0]  chr_bank;
        logic        dac_valid;
        logic [6:0]  dac_level;
    } res_t;

    typedef struct packed {
        logic                  we;
        logic [CHR_SLOT_W-1:0] slot;
        logic [7:0]            bank;
    } chr_wr_t;

    typedef struct packed {
        logic [7:0] prg32;
        logic [7:0] prg8;
        logic [7:0] chr;
    } masks_t;

    function automatic logic [7:0] limit_bank(input logic [7:0] v, input logic [7:0] mask);
        return (v > mask) ? (v & mask) : v;
    endfunction

    function automatic logic is_chr_addr(input logic [15:0] addr);
        return (addr[15:12] == HI_CHR_A) || (addr[15:12] == HI_CHR_B) ||
               (addr[15:12] == HI_CHR_D) || (addr[15:12] == HI_CHR_E);
    endfunction

    // Slot pair base from the upper nibble, odd slot from address bit 3
    function automatic logic [CHR_SLOT_W-1:0] chr_slot_of(input logic [15:0] addr);
        logic [1:0] pair;
        case (addr[15:12])
            HI_CHR_D: pair = 2'd0;
            HI_CHR_A: pair = 2'd1;
            HI_CHR_B: pair = 2'd2;
            HI_CHR_E: pair = 2'd3;
            default:  pair = 2'd0;
        endcase
        return {pair, addr[3]};
    endfunction

endpackage

### sv/bsm_in_if.sv
// Input channel of the mapper: valid/ready with one write or tick per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface bsm_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, mode, address, data, input ready);
    modport sink   (input valid, mode, address, data, output ready);
endinterface

### sv/bsm_out_if.sv
// Result channel of the mapper: valid/ready with one mapping snapshot per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface bsm_out_if;
    logic       valid;
    logic       ready;
    logic       irq_line;
    logic [1:0] mirroring;
    logic [7:0] prg_bank_32k;
    logic       prg_split_on;
    logic [7:0] prg_bank_8k_c000;
    logic       chr_write_valid;
    logic [2:0] chr_slot;
    logic [7:0] chr_bank;
    logic       dac_valid;
    logic [6:0] dac_level;

    modport source (output valid, irq_line, mirroring, prg_bank_32k, prg_split_on,
                    prg_bank_8k_c000, chr_write_valid, chr_slot, chr_bank,
                    dac_valid, dac_level, input ready);
    modport sink   (input valid, irq_line, mirroring, prg_bank_32k, prg_split_on,
                    prg_bank_8k_c000, chr_write_valid, chr_slot, chr_bank,
                    dac_valid, dac_level, output ready);
endinterface

### sv/bsm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bsm_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/bsm_ctrl.sv
// Register decode and update of the mapper: scalar state, IRQ counter, CHR merge.
// Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  bsm_pkg::item_t item,
    input  logic [7:0]     chr_old,
    input  bsm_pkg::masks_t masks,
    output bsm_pkg::res_t  res,
    output bsm_pkg::chr_wr_t chr_wr
);

    logic [1:0]  prg_hi_reg,  prg_hi_next;
    logic        split_dis_reg, split_dis_next;
    logic [1:0]  mirror_reg,  mirror_next;
    logic [15:0] cnt_reg,     cnt_next;
    logic        irq_en_reg,  irq_en_next;
    logic        irq_pend_reg, irq_pend_next;
    logic        dac_hit;
    logic [7:0]  chr_merged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_hi_reg    <= '0;
            split_dis_reg <= 1'b0;
            mirror_reg    <= '0;
            cnt_reg       <= '0;
            irq_en_reg    <= 1'b0;
            irq_pend_reg  <= 1'b0;
        end
        else if (fire)
        begin
            prg_hi_reg    <= prg_hi_next;
            split_dis_reg <= split_dis_next;
            mirror_reg    <= mirror_next;
            cnt_reg       <= cnt_next;
            irq_en_reg    <= irq_en_next;
            irq_pend_reg  <= irq_pend_next;
        end
    end

    always_comb
    begin
        prg_hi_next    = prg_hi_reg;
        split_dis_next = split_dis_reg;
        mirror_next    = mirror_reg;
        cnt_next       = cnt_reg;
        irq_en_next    = irq_en_reg;
        irq_pend_next  = irq_pend_reg;
        dac_hit        = 1'b0;

        if (item.mode)
        begin
            if (irq_en_reg)
            begin
                cnt_next = cnt_reg - 16'd1;
                if ((cnt_next == 16'd0) || cnt_next[15])
                begin
                    irq_pend_next = 1'b1;
                end
            end
        end
        else
        begin
            case (item.address[15:12])
                bsm_pkg::HI_MIR_PRG:
                begin
                    if (item.address[3:2] == bsm_pkg::OFF_0)
                    begin
                        mirror_next = item.data[1:0];
                    end
                    else if (item.address[11])
                    begin
                        dac_hit = 1'b1;
                    end
                    else
                    begin
                        prg_hi_next = item.data[3:2];
                    end
                end
                bsm_pkg::HI_SPLIT:
                begin
                    split_dis_next = item.data[0];
                end
                bsm_pkg::HI_IRQ:
                begin
                    case (item.address[3:2])
                        bsm_pkg::OFF_0:
                            cnt_next = (cnt_reg & 16'h01E0) | {11'd0, item.data[3:0], 1'b0};
                        bsm_pkg::OFF_1:
                            cnt_next = (cnt_reg & 16'h001E) | {7'd0, item.data[3:0], 5'd0};
                        bsm_pkg::OFF_2:
                        begin
                            irq_en_next   = item.data[1];
                            irq_pend_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Offset 4 replaces the high nibble, offset 0 the low nibble
    assign chr_merged = item.address[2] ? {item.data[3:0], chr_old[3:0]}
                                        : {chr_old[7:4], item.data[3:0]};

    assign chr_wr.we   = fire && !item.mode && bsm_pkg::is_chr_addr(item.address);
    assign chr_wr.slot = bsm_pkg::chr_slot_of(item.address);
    assign chr_wr.bank = bsm_pkg::limit_bank(chr_merged, masks.chr);

    always_comb
    begin
        res.irq_line         = irq_pend_next;
        res.mirroring        = mirror_next;
        res.prg_bank_32k     = bsm_pkg::limit_bank({6'd0, prg_hi_next}, masks.prg32);
        res.prg_split_on     = !split_dis_next;
        res.prg_bank_8k_c000 = split_dis_next ? 8'd0
                             : bsm_pkg::limit_bank({4'd0, prg_hi_next, 2'd0}, masks.prg8);
        res.chr_write_valid  = !item.mode && bsm_pkg::is_chr_addr(item.address);
        res.chr_slot         = res.chr_write_valid ? 3'(chr_wr.slot) : 3'd0;
        res.chr_bank         = res.chr_write_valid ? chr_wr.bank : 8'd0;
        res.dac_valid        = dac_hit;
        res.dac_level        = dac_hit ? {item.data[3:0], 3'd0} : 7'd0;
    end

endmodule

### sv/bank_switch_mapper_irq_top.sv
// Bank-switch mapper with CPU-cycle IRQ counter. Takes one CPU write or tick per
// clock unless the output stalls and returns one mapping snapshot per item via
// the stage and output registers. The eight CHR bank numbers live in a small RAM
// with a registered read: the slot is read when the item is accepted and written
// back as it leaves the stage, and a write to the slot just read is forwarded, so
// unstalled items follow each other at one per clock with no bubble. Valid bits
// give the zero reset of the CHR table without a clearing pass. Mask registers are
// written via the cfg port, by the user only while the block is idle; unenforced.
// Depends on bsm_pkg, bsm_in_if, bsm_out_if, bsm_ram, bsm_ctrl and the macro header.
`timescale 1ns / 1ps
`include "bank_switch_mapper_irq_top_macros.svh"

module bank_switch_mapper_irq_top (
    input  logic       clk,
    input  logic       rst_n,
    bsm_in_if.sink     req,
    bsm_out_if.source  rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    bsm_pkg::masks_t  masks_reg;
    bsm_pkg::item_t   s1_item_reg;
    logic             s1_vld_reg, s1_vld_next;
    logic             out_vld_reg, out_vld_next;
    bsm_pkg::res_t    out_res_reg;
    logic [bsm_pkg::CHR_SLOTS-1:0] chr_vld_reg;
    logic             rd_vld_reg;
    logic             fwd_hit_reg;
    logic [7:0]       fwd_data_reg;

    logic             req_fire;
    logic             out_free;
    logic             s1_fire;
    logic [bsm_pkg::CHR_SLOT_W-1:0] rd_slot;
    logic [7:0]       ram_rdata;
    logic [7:0]       chr_old;
    bsm_pkg::res_t    res;
    bsm_pkg::chr_wr_t chr_wr;

    assign out_free  = !out_vld_reg || rsp.ready;
    assign s1_fire   = s1_vld_reg && out_free;
    assign req.ready = !s1_vld_reg || out_free;
    assign req_fire  = req.valid && req.ready;
    assign rd_slot   = bsm_pkg::chr_slot_of(req.address);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg <= '{prg32: 8'hFF, prg8: 8'hFF, chr: 8'hFF};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsm_pkg::CFG_PRG32: masks_reg.prg32 <= cfg_data;
                bsm_pkg::CFG_PRG8:  masks_reg.prg8  <= cfg_data;
                bsm_pkg::CFG_CHR:   masks_reg.chr   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (req_fire)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (s1_fire)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            chr_vld_reg <= '0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            if (chr_wr.we)
            begin
                chr_vld_reg[chr_wr.slot] <= 1'b1;
            end
        end
    end

    // Capture the item with its slot read; forward the write-back that lands
    // on the same edge
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_item_reg  <= '{mode: req.mode, address: req.address, data: req.data};
            rd_vld_reg   <= chr_vld_reg[rd_slot];
            fwd_hit_reg  <= chr_wr.we && (chr_wr.slot == rd_slot);
            fwd_data_reg <= chr_wr.bank;
        end
        if (s1_fire)
        begin
            out_res_reg <= res;
        end
    end

    bsm_ram #(
        .DEPTH (bsm_pkg::CHR_SLOTS),
        .WIDTH (8)
    ) u_chr_ram (
        .clk   (clk),
        .we    (chr_wr.we),
        .waddr (chr_wr.slot),
        .wdata (chr_wr.bank),
        .re    (req_fire),
        .raddr (rd_slot),
        .rdata (ram_rdata)
    );

    assign chr_old = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? ram_rdata : 8'd0);

    bsm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (s1_fire),
        .item    (s1_item_reg),
        .chr_old (chr_old),
        .masks   (masks_reg),
        .res     (res),
        .chr_wr  (chr_wr)
    );

    assign rsp.valid            = out_vld_reg;
    assign rsp.irq_line         = out_res_reg.irq_line;
    assign rsp.mirroring        = out_res_reg.mirroring;
    assign rsp.prg_bank_32k     = out_res_reg.prg_bank_32k;
    assign rsp.prg_split_on     = out_res_reg.prg_split_on;
    assign rsp.prg_bank_8k_c000 = out_res_reg.prg_bank_8k_c000;
    assign rsp.chr_write_valid  = out_res_reg.chr_write_valid;
    assign rsp.chr_slot         = out_res_reg.chr_slot;
    assign rsp.chr_bank         = out_res_reg.chr_bank;
    assign rsp.dac_valid        = out_res_reg.dac_valid;
    assign rsp.dac_level        = out_res_reg.dac_level;

    `BSM_ASSERT_NOW(a_chr_wr_on_fire, chr_wr.we, s1_fire, "CHR write-back without stage advance")
    `BSM_ASSERT_NOW(a_no_accept_on_stall, s1_vld_reg && !s1_fire, !req_fire, "item accepted over a stalled stage")
    `BSM_ASSERT_NEXT(a_fire_fills_out, s1_fire, out_vld_reg, "advanced item missing from output")
    `BSM_ASSERT_NEXT(a_wr_sets_valid, chr_wr.we, chr_vld_reg[$past(chr_wr.slot)], "CHR slot not marked valid after write")

endmodule

### tb/bank_switch_mapper_irq_checker.sv
// Checker for the bank-switch mapper: watches both channels and the cfg port,
// predicts each mapping snapshot and compares it with what the block returns.
// Depends on bsm_pkg, bsm_in_if and bsm_out_if.
`timescale 1ns / 1ps

module bank_switch_mapper_irq_checker
    import bsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bsm_in_if          req,
    bsm_out_if         rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         waiting
);

    // Shadow of the mapper state
    masks_t             masks;
    logic [3:0]         prg_sel;
    logic               split_off;
    logic [7:0]         chr_banks [CHR_SLOTS];
    logic [1:0]         mirror;
    logic signed [15:0] irq_count;
    logic               irq_on;
    logic               irq_flag;

    res_t snapshot_q [$];

    function automatic logic [7:0] fit_bank(input logic [7:0] num, input logic [7:0] mask);
        return (num > mask) ? (num & mask) : num;
    endfunction

    // Apply one write or tick to the shadow state and return the snapshot after it
    function automatic res_t mapper_snapshot(input item_t it);
        res_t       r;
        logic [1:0] pair;
        logic [2:0] slot;
        logic [7:0] nv;
        r = '0;
        if (it.mode) begin
            if (irq_on) begin
                irq_count = irq_count - 16'sd1;
                if (irq_count <= 16'sd0)
                    irq_flag = 1'b1;
            end
        end
        else begin
            case (it.address[15:12])
                HI_MIR_PRG:
                    if (it.address[3:2] == OFF_0)
                        mirror = it.data[1:0];
                    else if (it.address[11]) begin
                        r.dac_valid = 1'b1;
                        r.dac_level = {it.data[3:0], 3'b000};
                    end
                    else
                        prg_sel = {it.data[3:2], 2'b00};
                HI_SPLIT:
                    split_off = it.data[0];
                HI_CHR_A, HI_CHR_B, HI_CHR_D, HI_CHR_E:
                begin
                    case (it.address[15:12])
                        HI_CHR_A: pair = 2'd1;
                        HI_CHR_B: pair = 2'd2;
                        HI_CHR_E: pair = 2'd3;
                        default:  pair = 2'd0;
                    endcase
                    slot = {pair, it.address[3]};
                    nv = chr_banks[slot];
                    if (it.address[2])
                        nv[7:4] = it.data[3:0];
                    else
                        nv[3:0] = it.data[3:0];
                    nv = fit_bank(nv, masks.chr);
                    chr_banks[slot] = nv;
                    r.chr_write_valid = 1'b1;
                    r.chr_slot = slot;
                    r.chr_bank = nv;
                end
                HI_IRQ:
                    case (it.address[3:2])
                        OFF_0: irq_count = {7'b0, irq_count[8:5], it.data[3:0], 1'b0};
                        OFF_1: irq_count = {7'b0, it.data[3:0], irq_count[4:1], 1'b0};
                        OFF_2:
                        begin
                            irq_on = it.data[1];
                            irq_flag = 1'b0;
                        end
                        default: ;
                    endcase
                default: ;
            endcase
        end
        r.irq_line = irq_flag;
        r.mirroring = mirror;
        r.prg_bank_32k = fit_bank({6'b0, prg_sel[3:2]}, masks.prg32);
        r.prg_split_on = !split_off;
        r.prg_bank_8k_c000 = split_off ? 8'h00 : fit_bank({4'b0, prg_sel}, masks.prg8);
        return r;
    endfunction

    function automatic string res_text(input res_t r);
        return $sformatf("irq=%0d mir=%0d prg32=%02h split=%0d prg8=%02h chr=%0d/%0d/%02h dac=%0d/%02h",
                         r.irq_line, r.mirroring, r.prg_bank_32k, r.prg_split_on,
                         r.prg_bank_8k_c000, r.chr_write_valid, r.chr_slot, r.chr_bank,
                         r.dac_valid, r.dac_level);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t  got;
        res_t  want;
        item_t it;
        if (!rst_n) begin
            masks = '{prg32: 8'hFF, prg8: 8'hFF, chr: 8'hFF};
            prg_sel = '0;
            split_off = 1'b0;
            for (int i = 0; i < CHR_SLOTS; i++)
                chr_banks[i] = '0;
            mirror = '0;
            irq_count = '0;
            irq_on = 1'b0;
            irq_flag = 1'b0;
            snapshot_q.delete();
            waiting = 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                got = '{irq_line: rsp.irq_line, mirroring: rsp.mirroring,
                        prg_bank_32k: rsp.prg_bank_32k, prg_split_on: rsp.prg_split_on,
                        prg_bank_8k_c000: rsp.prg_bank_8k_c000,
                        chr_write_valid: rsp.chr_write_valid, chr_slot: rsp.chr_slot,
                        chr_bank: rsp.chr_bank, dac_valid: rsp.dac_valid,
                        dac_level: rsp.dac_level};
                if (snapshot_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected beat: %s", $realtime, res_text(got));
                end
                else begin
                    want = snapshot_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch\n  exp %s\n  got %s", $realtime,
                                     res_text(want), res_text(got));
                    end
                end
            end
            if (req.valid && req.ready) begin
                it = '{mode: req.mode, address: req.address, data: req.data};
                snapshot_q.push_back(mapper_snapshot(it));
            end
            if (cfg_we)
                case (cfg_index)
                    CFG_PRG32: masks.prg32 = cfg_data;
                    CFG_PRG8:  masks.prg8 = cfg_data;
                    CFG_CHR:   masks.chr = cfg_data;
                    default: ;
                endcase
            waiting = snapshot_q.size();
        end
    end

endmodule

### tb/bank_switch_mapper_irq_top_tb.sv
// Testbench top for the bank-switch mapper: clock, reset, stimulus, idling on
// both channels, mask phases and the verdict. Checking is done by the checker.
// Depends on bsm_pkg, bsm_in_if, bsm_out_if, the mapper RTL and the checker.
`timescale 1ns / 1ps

module bank_switch_mapper_irq_top_tb;
    import bsm_pkg::*;

    localparam int          IDLE_LIMIT = 1000;
    localparam logic [1:0]  OFF_3      = 2'd3;
    localparam logic [3:0]  HI_NONE    = 4'h8;
    localparam logic [1:0]  CFG_UNUSED = 2'd3;
    localparam logic [15:0] DAC_BIT    = 16'h0800;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         errors;
    int         outstanding;
    int         idle_cycles = 0;
    bit         calm = 1'b0;

    bsm_in_if  req_ch ();
    bsm_out_if rsp_ch ();

    bank_switch_mapper_irq_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bank_switch_mapper_irq_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (errors),
        .waiting    (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        if (rst_n)
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 10);

    // End the run when neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [15:0] reg_addr(input logic [3:0] hi, input logic [1:0] off);
        return {hi, 8'h00, off, 2'b00};
    endfunction

    // Hold valid until the beat is taken; an optional gap goes in front
    task automatic send_item(input item_t it);
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= it.mode;
        req_ch.address <= it.address;
        req_ch.data <= it.data;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic cpu_write(input logic [15:0] addr, input logic [7:0] value);
        send_item('{mode: 1'b0, address: addr, data: value});
    endtask

    task automatic cpu_tick();
        send_item('{mode: 1'b1, address: 16'($urandom), data: 8'($urandom)});
    endtask

    // Drop valid and wait until every snapshot is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_masks(input logic [7:0] p32, input logic [7:0] p8,
                                 input logic [7:0] chr, input bit stray);
        logic [1:0] regs [4];
        logic [7:0] vals [4];
        regs = '{CFG_PRG32, CFG_PRG8, CFG_CHR, CFG_UNUSED};
        vals = '{p32, p8, chr, 8'($urandom)};
        for (int i = 0; i < (stray ? 4 : 3); i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_items(input int count);
        item_t it;
        int    pick;
        repeat (count)
        begin
            it.mode = 1'b0;
            it.address = 16'($urandom);
            it.data = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 35)
                it.mode = 1'b1;
            else if (pick < 92)
            begin
                case ($urandom_range(0, 8))
                    0:       it.address[15:12] = HI_MIR_PRG;
                    1:       it.address[15:12] = HI_CHR_A;
                    2:       it.address[15:12] = HI_CHR_B;
                    3:       it.address[15:12] = HI_SPLIT;
                    4:       it.address[15:12] = HI_CHR_D;
                    5:       it.address[15:12] = HI_CHR_E;
                    default: it.address[15:12] = HI_IRQ;
                endcase
                // Keep counter loads small so the IRQ fires often
                if (it.address[15:12] == HI_IRQ && it.address[3:2] != OFF_2
                    && $urandom_range(0, 1))
                    it.data[3:1] = 3'b000;
            end
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = 1'b0;
        req_ch.address = '0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_masks(8'hFF, 8'hFF, 8'hFF, 1'b0);
        cpu_write(reg_addr(HI_MIR_PRG, OFF_0), 8'hFF);
        cpu_write(reg_addr(HI_MIR_PRG, OFF_0), 8'h01);
        cpu_write(reg_addr(HI_MIR_PRG, OFF_1), 8'hFF);
        cpu_write(reg_addr(HI_MIR_PRG, OFF_2) | DAC_BIT, 8'h0F);
        cpu_write(reg_addr(HI_MIR_PRG, OFF_3) | DAC_BIT, 8'hF0);
        cpu_write(reg_addr(HI_SPLIT, OFF_3), 8'h01);
        cpu_write(reg_addr(HI_SPLIT, OFF_0), 8'h00);
        cpu_write(reg_addr(HI_CHR_D, OFF_0), 8'hFF);
        cpu_write(reg_addr(HI_CHR_D, OFF_1), 8'hFF);
        cpu_write(reg_addr(HI_CHR_D, OFF_2), 8'h05);
        cpu_write(reg_addr(HI_CHR_A, OFF_3), 8'h0A);
        cpu_write(reg_addr(HI_CHR_A, OFF_0), 8'h03);
        cpu_write(reg_addr(HI_CHR_B, OFF_1), 8'h0C);
        cpu_write(reg_addr(HI_CHR_E, OFF_2), 8'h00);
        cpu_write(reg_addr(HI_CHR_E, OFF_1), 8'h07);
        cpu_write(reg_addr(HI_IRQ, OFF_0), 8'hFF);
        cpu_write(reg_addr(HI_IRQ, OFF_1), 8'hFF);
        cpu_write(reg_addr(HI_IRQ, OFF_0), 8'h01);
        cpu_write(reg_addr(HI_IRQ, OFF_1), 8'h00);
        cpu_write(reg_addr(HI_IRQ, OFF_2), 8'h02);
        cpu_tick();
        cpu_tick();    // counter reaches zero: IRQ rises
        cpu_tick();
        cpu_write(reg_addr(HI_IRQ, OFF_2), 8'h00);
        cpu_tick();
        cpu_write(reg_addr(HI_IRQ, OFF_3), 8'($urandom));
        cpu_write(reg_addr(HI_NONE, OFF_0), 8'($urandom));
        random_items(300);
        drain();

        program_masks(8'h00, 8'h00, 8'h00, 1'b0);
        random_items(350);
        drain();

        // No idling on either side in this phase
        calm = 1'b1;
        program_masks(8'h03, 8'h0F, 8'h07, 1'b0);
        random_items(400);
        drain();
        calm = 1'b0;

        program_masks(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        random_items(400);
        drain();

        // Run the counter from a small load down through zero into negative values
        program_masks(8'hFF, 8'hFF, 8'hFF, 1'b0);
        cpu_write(reg_addr(HI_IRQ, OFF_0), 8'h03);
        cpu_write(reg_addr(HI_IRQ, OFF_1), 8'h00);
        cpu_write(reg_addr(HI_IRQ, OFF_2), 8'h02);
        repeat (20) cpu_tick();
        cpu_write(reg_addr(HI_IRQ, OFF_2), 8'h02);
        repeat (3) cpu_tick();
        random_items(350);
        drain();

        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
